>>> design/pm_pkg.sv
// ----------------------------------------------------------------------------
// pm_pkg: shared types and constants of the polynomial multiplier
// Command codes, sequencer states and the result record passed from the
// convolution engine to the output stage.
// ----------------------------------------------------------------------------
package pm_pkg;

  // product coefficient width and internal product extension width
  localparam int OUT_W = 40;
  localparam int EXT_W = 64;

  // command codes carried in the low bits of the input tdata
  typedef enum logic [1:0] {
    CMD_LOAD_A   = 2'd0,
    CMD_LOAD_B   = 2'd1,
    CMD_MULTIPLY = 2'd2
  } pm_cmd_t;

  // convolution sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } pm_state_t;

  // one product coefficient on its way to the output register
  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
    logic             dropped;
  } pm_result_t;

endpackage

>>> design/pm_ram.sv
// ----------------------------------------------------------------------------
// pm_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pm_conv.sv
// ----------------------------------------------------------------------------
// pm_conv: convolution engine
// Walks the product coefficients highest degree first. For each one it
// issues the pairs a[i], b[k-i] to the two stores, multiplies the read data,
// accumulates modulo 2^40 and hands the finished coefficient to the output.
// ----------------------------------------------------------------------------
module pm_conv #(
  parameter int MAX_TERMS  = 16,
  parameter int COEFF_BITS = 16,
  parameter int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  parameter int CNT_W      = $clog2(MAX_TERMS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CNT_W-1:0]      count_a,
  input  logic [CNT_W-1:0]      count_b,
  input  logic                  drop,
  output logic                  busy,
  output logic [IDX_W-1:0]      a_addr,
  output logic [IDX_W-1:0]      b_addr,
  input  logic [COEFF_BITS-1:0] a_data,
  input  logic [COEFF_BITS-1:0] b_data,
  output logic                  res_valid,
  output pm_pkg::pm_result_t    res,
  input  logic                  res_ready
);

  import pm_pkg::*;

  localparam int K_W = $clog2(2 * MAX_TERMS);
  localparam int P_W = 2 * COEFF_BITS;

  pm_state_t state, state_next;

  logic [CNT_W-1:0]       ca, cb;
  logic                   drop_r;
  logic                   empty;
  logic [K_W-1:0]         k;
  logic [K_W-1:0]         k_end;
  logic [IDX_W-1:0]       i;
  logic [IDX_W-1:0]       i_hi;
  logic [K_W-1:0]         j_full;
  logic [K_W:0]           lo_sum;
  logic [IDX_W-1:0]       i_lo;
  logic [IDX_W-1:0]       i_top;
  logic                   issue;
  logic                   v1, v2;
  logic signed [P_W-1:0]  prod;
  logic signed [EXT_W-1:0] prod_ext;
  logic [OUT_W-1:0]       acc;
  logic                   k_is_last;

  // pair addresses for the current term
  assign j_full = k - K_W'(i);
  assign a_addr = i;
  assign b_addr = j_full[IDX_W-1:0];
  assign issue  = (state == ST_ISSUE);

  // term range of coefficient k: max(0, k-cb+1) .. min(k, ca-1)
  assign lo_sum = {1'b0, k} + (K_W + 1)'(1);
  always_comb begin
    if (lo_sum >= (K_W + 1)'(cb)) begin
      i_lo = IDX_W'(lo_sum - (K_W + 1)'(cb));
    end else begin
      i_lo = '0;
    end
    if (k < K_W'(ca) - K_W'(1)) begin
      i_top = k[IDX_W-1:0];
    end else begin
      i_top = IDX_W'(ca - CNT_W'(1));
    end
  end

  assign k_is_last = empty || (k == k_end);
  assign busy      = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result handoff
  always_comb begin
    state_next  = state;
    res_valid   = 1'b0;
    res.value   = acc;
    res.last    = k_is_last;
    res.dropped = drop_r;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (count_a == '0 || count_b == '0) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (i == i_hi) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = k_is_last ? ST_IDLE : ST_SETUP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // run parameters and term counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      ca     <= count_a;
      cb     <= count_b;
      drop_r <= drop;
      empty  <= (count_a == '0 || count_b == '0);
      k      <= '0;
      k_end  <= K_W'(count_a) + K_W'(count_b) - K_W'(2);
    end else if (state == ST_EMIT && res_ready) begin
      k <= k + K_W'(1);
    end
    if (state == ST_SETUP) begin
      i    <= i_lo;
      i_hi <= i_top;
    end else if (issue) begin
      i <= i + IDX_W'(1);
    end
  end

  // read and multiply stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // multiply the read pair, then accumulate
  assign prod_ext = EXT_W'(prod);
  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
    if ((state == ST_IDLE && start) || state == ST_SETUP) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod_ext[OUT_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // issued pairs stay inside the loaded operands
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (CNT_W'(i) < ca && j_full < K_W'(cb)))
    else $error("pm_conv: term pair outside operand range");

  // a result is only offered once the pipeline is empty
  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!v1 && !v2))
    else $error("pm_conv: result offered while products in flight");

  // the product stage only follows a read stage
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("pm_conv: product stage without read stage");

  // the last result of a run returns the engine to idle once taken
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> (state == ST_IDLE))
    else $error("pm_conv: engine busy after final result");
`endif

endmodule

>>> design/polynomial_multiply.sv
// ----------------------------------------------------------------------------
// polynomial_multiply: integer polynomial multiplier
// Loads two coefficient stores and streams out their product coefficients.
// ----------------------------------------------------------------------------
// A load transaction (command 0 for A, 1 for B) writes one coefficient,
// highest degree first; tlast closes the polynomial and a later load to a
// closed polynomial starts it over. Coefficients past MAX_TERMS are dropped
// and set the sticky dropped flag. A multiply (command 2) occupies the block
// until its final result is taken by the output register. Each product
// coefficient passes through setup, then term pairs issued one per cycle,
// set by the single read port of each coefficient RAM feeding one
// multiplier, then pipeline drain and a handoff that waits for the output.
// An empty operand gives a single zero result.
// Input is not accepted while a multiply is running; the output register
// lets a new transaction in while the final result still waits.
module polynomial_multiply #(
  parameter int MAX_TERMS  = 16,
  parameter int COEFF_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [((COEFF_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,  // command[1:0], coeff,
                                                               // zero pad
  input  logic                    s_tlast,   // last_coeff
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [pm_pkg::OUT_W-1:0] m_tdata,  // product_coeff[39:0]
  output logic                    m_tlast,   // last
  output logic                    m_tuser    // dropped
);

  import pm_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  logic [1:0]            command;
  logic [COEFF_BITS-1:0] coeff;
  logic                  accept;
  logic                  busy;

  logic [CNT_W-1:0]      count_a, count_b;
  logic                  closed_a, closed_b;
  logic                  overflow_seen;
  logic [CNT_W-1:0]      fill_a, fill_b;
  logic                  we_a, we_b;
  logic                  start;

  logic [IDX_W-1:0]      a_addr, b_addr;
  logic [COEFF_BITS-1:0] a_data, b_data;
  logic                  res_valid, res_ready;
  pm_result_t            res;

  // input fields
  assign command  = s_tdata[1:0];
  assign coeff    = s_tdata[COEFF_BITS+1:2];
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // write position: a closed polynomial restarts at zero
  assign fill_a = closed_a ? '0 : count_a;
  assign fill_b = closed_b ? '0 : count_b;

  // decode of the accepted transaction
  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    start = 1'b0;
    if (accept) begin
      case (command)
        CMD_LOAD_A:   we_a  = (fill_a < CNT_W'(MAX_TERMS));
        CMD_LOAD_B:   we_b  = (fill_b < CNT_W'(MAX_TERMS));
        CMD_MULTIPLY: start = 1'b1;
        default: ;
      endcase
    end
  end

  // operand counts, closed flags and sticky drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      closed_a      <= 1'b1;
      closed_b      <= 1'b1;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      case (command)
        CMD_LOAD_A: begin
          closed_a <= s_tlast;
          if (we_a) begin
            count_a <= fill_a + CNT_W'(1);
          end else begin
            count_a       <= fill_a;
            overflow_seen <= 1'b1;
          end
        end
        CMD_LOAD_B: begin
          closed_b <= s_tlast;
          if (we_b) begin
            count_b <= fill_b + CNT_W'(1);
          end else begin
            count_b       <= fill_b;
            overflow_seen <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // coefficient stores
  pm_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_TERMS), .AW(IDX_W)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (fill_a[IDX_W-1:0]),
    .wdata (coeff),
    .raddr (a_addr),
    .rdata (a_data)
  );

  pm_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_TERMS), .AW(IDX_W)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (fill_b[IDX_W-1:0]),
    .wdata (coeff),
    .raddr (b_addr),
    .rdata (b_data)
  );

  // convolution engine
  pm_conv #(
    .MAX_TERMS  (MAX_TERMS),
    .COEFF_BITS (COEFF_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .count_a   (count_a),
    .count_b   (count_b),
    .drop      (overflow_seen),
    .busy      (busy),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .a_data    (a_data),
    .b_data    (b_data),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res.value;
      m_tlast <= res.last;
      m_tuser <= res.dropped;
    end
  end

endmodule
